// ----- hw/rtl/dspring_pkg.sv -----
// Package: request codes, register indexes and transaction payload types for the damped spring.
package dspring_pkg;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_TARGET  = 2'd1,
        REQ_SNAP    = 2'd2,
        REQ_IMPULSE = 2'd3
    } t_req;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIFFNESS = 3'd0,
        CFG_DAMPING   = 3'd1,
        CFG_POS_LIMIT = 3'd2,
        CFG_VEL_LIMIT = 3'd3
    } t_cfg_idx;

    localparam int VAL_W   = 32;
    localparam int COEF_W  = 17;
    localparam int LIMIT_W = 31;

    // Input transaction payload
    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [VAL_W-1:0] x_operand;
        logic signed [VAL_W-1:0] y_operand;
    } t_in_item;

    // Result transaction payload
    typedef struct packed {
        logic signed [VAL_W-1:0] x_position;
        logic signed [VAL_W-1:0] y_position;
        logic                    settled;
    } t_out_item;

endpackage

// ----- hw/rtl/dspring_axis.sv -----
// Module: one spring axis, holding position, velocity and target and applying one request.
module dspring_axis #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  dspring_pkg::t_req                     i_req,
    input  logic signed [dspring_pkg::VAL_W-1:0]  i_operand,
    input  logic [dspring_pkg::COEF_W-1:0]        i_stiffness,
    input  logic [dspring_pkg::COEF_W-1:0]        i_damping,
    input  logic [dspring_pkg::LIMIT_W-1:0]       i_pos_limit,
    input  logic [dspring_pkg::LIMIT_W-1:0]       i_vel_limit,
    output logic signed [dspring_pkg::VAL_W-1:0]  o_position,
    output logic                                  o_settled
);

    localparam int VW     = dspring_pkg::VAL_W;
    localparam int PROD_W = dspring_pkg::COEF_W + 1 + VW;
    localparam int EXT_W  = (FRACTION_BITS + VW > PROD_W) ? FRACTION_BITS + VW : PROD_W;

    logic signed [VW-1:0]     r_pos, r_vel, r_tgt;
    logic signed [VW-1:0]     n_pos, n_vel, n_tgt;
    logic signed [VW-1:0]     disp;
    logic signed [PROD_W-1:0] prod_k, prod_d;
    logic signed [EXT_W-1:0]  ext_k, ext_d;
    logic [VW-1:0]            term_k, term_d;
    logic [VW-1:0]            vel_tick, pos_tick;
    logic [VW-1:0]            disp_mag, vel_mag;

    // Spring and damping products, floor-shifted back to fixed point
    always_comb begin
        disp     = r_pos - r_tgt;
        prod_k   = $signed({1'b0, i_stiffness}) * disp;
        prod_d   = $signed({1'b0, i_damping}) * r_vel;
        ext_k    = EXT_W'(prod_k);
        ext_d    = EXT_W'(prod_d);
        term_k   = ext_k[FRACTION_BITS +: VW];
        term_d   = ext_d[FRACTION_BITS +: VW];
        vel_tick = VW'(r_vel) - term_k - term_d;
        pos_tick = VW'(r_pos) + vel_tick;
    end

    // Select the next state by request
    always_comb begin
        n_pos = r_pos;
        n_vel = r_vel;
        n_tgt = r_tgt;
        case (i_req)
            dspring_pkg::REQ_TICK: begin
                n_vel = vel_tick;
                n_pos = pos_tick;
            end
            dspring_pkg::REQ_TARGET: begin
                n_tgt = i_operand;
            end
            dspring_pkg::REQ_SNAP: begin
                n_pos = i_operand;
                n_tgt = i_operand;
                n_vel = '0;
            end
            dspring_pkg::REQ_IMPULSE: begin
                n_vel = r_vel + i_operand;
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    // Advance the state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vel <= '0;
            r_tgt <= '0;
        end else if (i_en) begin
            r_pos <= n_pos;
            r_vel <= n_vel;
            r_tgt <= n_tgt;
        end
    end

    // Settle test on the stored state; the most negative value never passes
    always_comb begin
        disp_mag  = disp[VW-1]  ? VW'(-disp)  : VW'(disp);
        vel_mag   = r_vel[VW-1] ? VW'(-r_vel) : VW'(r_vel);
        o_settled = (disp_mag < {1'b0, i_pos_limit}) && (vel_mag < {1'b0, i_vel_limit});
    end

    assign o_position = r_pos;

endmodule

// ----- hw/rtl/damped_spring_2d_step_core.sv -----
// Top level: two-axis damped spring with configuration registers and a two-entry result queue.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------------
//   in       | to core   | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//   out      | from core | o_out_valid / i_out_ready | o_out_data (t_out_item)
//   cfg      | to core   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction is accepted per cycle while the queue has room; its result is offered
// after the state update in the axis registers, then the settle test into the result queue.
// Reset (i_rst_n low at a clock edge) clears the axis state, restores the register
// defaults and empties the queue; both input readies stay low while it is held.
// A stalled output only holds off input once the queue and the pending result
// would fill both entries.
module damped_spring_2d_step_core #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  dspring_pkg::t_in_item                   i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output dspring_pkg::t_out_item                  o_out_data,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [dspring_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                             i_cfg_data
);

    localparam int CW = dspring_pkg::COEF_W;
    localparam int LW = dspring_pkg::LIMIT_W;
    localparam longint ONE = 64'd1 << FRACTION_BITS;
    localparam logic [CW-1:0] STIFF_RST = CW'(ONE / 5);
    localparam logic [CW-1:0] DAMP_RST  = CW'(ONE / 2);
    localparam logic [LW-1:0] PLIM_RST  = LW'(ONE / 2);
    localparam logic [LW-1:0] VLIM_RST  = LW'(ONE / 10);

    logic [CW-1:0] r_stiffness, r_damping;
    logic [LW-1:0] r_pos_limit, r_vel_limit;

    logic                    in_fire, out_fire;
    logic                    r_pend;
    logic [1:0]              r_count;
    logic                    r_wr_ptr, r_rd_ptr;
    dspring_pkg::t_out_item  r_queue [2];
    dspring_pkg::t_out_item  push_item;
    logic [2:0]              fill_after;
    dspring_pkg::t_req       req;
    logic                    settled_x, settled_y;
    logic signed [31:0]      pos_x, pos_y;

    assign o_cfg_ready = i_rst_n;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness <= STIFF_RST;
            r_damping   <= DAMP_RST;
            r_pos_limit <= PLIM_RST;
            r_vel_limit <= VLIM_RST;
        end else if (i_cfg_valid) begin
            case (dspring_pkg::t_cfg_idx'(i_cfg_index))
                dspring_pkg::CFG_STIFFNESS: r_stiffness <= i_cfg_data[CW-1:0];
                dspring_pkg::CFG_DAMPING:   r_damping   <= i_cfg_data[CW-1:0];
                dspring_pkg::CFG_POS_LIMIT: r_pos_limit <= i_cfg_data[LW-1:0];
                dspring_pkg::CFG_VEL_LIMIT: r_vel_limit <= i_cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign req = dspring_pkg::t_req'(i_in_data.req_type);

    dspring_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_x (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (in_fire),
        .i_req       (req),
        .i_operand   (i_in_data.x_operand),
        .i_stiffness (r_stiffness),
        .i_damping   (r_damping),
        .i_pos_limit (r_pos_limit),
        .i_vel_limit (r_vel_limit),
        .o_position  (pos_x),
        .o_settled   (settled_x)
    );

    dspring_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_y (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (in_fire),
        .i_req       (req),
        .i_operand   (i_in_data.y_operand),
        .i_stiffness (r_stiffness),
        .i_damping   (r_damping),
        .i_pos_limit (r_pos_limit),
        .i_vel_limit (r_vel_limit),
        .o_position  (pos_y),
        .o_settled   (settled_y)
    );

    // Handshakes; admit input only if the queue keeps room for its result
    always_comb begin
        out_fire   = o_out_valid && i_out_ready;
        fill_after = 3'({1'b0, r_count}) + 3'(r_pend) - 3'(out_fire);
        o_in_ready = i_rst_n && (fill_after < 3'd2);
        in_fire    = i_in_valid && o_in_ready;
        push_item.x_position = pos_x;
        push_item.y_position = pos_y;
        push_item.settled    = settled_x && settled_y;
    end

    // Track the pending result and the queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_count  <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_pend  <= in_fire;
            r_count <= 2'(r_count + 2'(r_pend) - 2'(out_fire));
            if (r_pend) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (out_fire) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // Capture the result of the previous transaction
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_queue[r_wr_ptr] <= push_item;
        end
    end

    assign o_out_valid = (r_count != 2'd0);
    assign o_out_data  = r_queue[r_rd_ptr];

endmodule

// ----- hw/rtl/dspring_checker.sv -----
// Checker: port-level assertions for the damped spring core, bound to the top level.
module dspring_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input dspring_pkg::t_out_item            o_out_data
);

    // Hold the result while the consumer stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // Clear the result queue on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // Offer a result once each accepted transaction has passed the axis registers into the queue
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> ##1 o_out_valid)
        else $error("no result after accepted transaction");

    // Keep accepting while no result waits
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind damped_spring_2d_step_core dspring_checker u_dspring_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- tb/sv/tb_damped_spring_2d_step_core.sv -----
`timescale 1ns / 1ps
// Testbench for the two-axis damped spring core: spring state predictor, stimulus and checks.

// Tracks the spring state and holds the positions and settle flags each request should produce
class spring_scoreboard #(int FRAC = 16);
    logic [16:0] stiffness;
    logic [16:0] damping;
    logic [30:0] pos_limit;
    logic [30:0] vel_limit;
    logic [31:0] position [2];
    logic [31:0] velocity [2];
    logic [31:0] target [2];
    dspring_pkg::t_out_item pending_positions [$];
    int failures;
    int checked;

    function new();
        failures  = 0;
        checked   = 0;
        stiffness = 17'd13107;
        damping   = 17'd32768;
        pos_limit = 31'd32768;
        vel_limit = 31'd6553;
        for (int a = 0; a < 2; a++) begin
            position[a] = '0;
            velocity[a] = '0;
            target[a]   = '0;
        end
    endfunction

    // Mirror a configuration register write
    function void write_register(dspring_pkg::t_cfg_idx idx, logic [31:0] value);
        case (idx)
            dspring_pkg::CFG_STIFFNESS: stiffness = value[16:0];
            dspring_pkg::CFG_DAMPING:   damping   = value[16:0];
            dspring_pkg::CFG_POS_LIMIT: pos_limit = value[30:0];
            dspring_pkg::CFG_VEL_LIMIT: vel_limit = value[30:0];
            default: ;
        endcase
    endfunction

    // Unsigned coefficient times signed value, floor-shifted, low 32 bits kept
    function logic [31:0] coef_product(logic [16:0] coef, logic [31:0] v);
        longint prod;
        prod = longint'(coef) * longint'($signed(v));
        prod = prod >>> FRAC;
        return prod[31:0];
    endfunction

    // An axis rests when both offset and speed magnitudes are strictly under their limits
    function bit axis_at_rest(int a);
        logic [31:0] disp;
        logic [31:0] disp_mag;
        logic [31:0] vel_mag;
        disp     = position[a] - target[a];
        disp_mag = disp[31] ? 32'd0 - disp : disp;
        vel_mag  = velocity[a][31] ? 32'd0 - velocity[a] : velocity[a];
        return (disp_mag < {1'b0, pos_limit}) && (vel_mag < {1'b0, vel_limit});
    endfunction

    // Advance the state for one accepted request and queue the result it yields
    function void note_request(dspring_pkg::t_in_item req);
        logic [31:0] operand [2];
        logic [31:0] accel;
        dspring_pkg::t_out_item want;
        operand[0] = req.x_operand;
        operand[1] = req.y_operand;
        for (int a = 0; a < 2; a++) begin
            case (dspring_pkg::t_req'(req.req_type))
                dspring_pkg::REQ_TICK: begin
                    accel = 32'd0 - coef_product(stiffness, position[a] - target[a])
                          - coef_product(damping, velocity[a]);
                    velocity[a] = velocity[a] + accel;
                    position[a] = position[a] + velocity[a];
                end
                dspring_pkg::REQ_TARGET: begin
                    target[a] = operand[a];
                end
                dspring_pkg::REQ_SNAP: begin
                    position[a] = operand[a];
                    target[a]   = operand[a];
                    velocity[a] = '0;
                end
                default: begin
                    velocity[a] = velocity[a] + operand[a];
                end
            endcase
        end
        want.x_position = position[0];
        want.y_position = position[1];
        want.settled    = axis_at_rest(0) && axis_at_rest(1);
        pending_positions.push_back(want);
    endfunction

    // Compare one result transaction against the oldest queued prediction
    function void check_result(dspring_pkg::t_out_item got);
        dspring_pkg::t_out_item want;
        checked++;
        if (pending_positions.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result %0d: x %h y %h settled %0b",
                         checked, got.x_position, got.y_position, got.settled);
            return;
        end
        want = pending_positions.pop_front();
        if (got.x_position !== want.x_position || got.y_position !== want.y_position ||
            got.settled !== want.settled) begin
            failures++;
            if (failures <= 10)
                $display({"mismatch on result %0d: x exp %h got %h, y exp %h got %h, ",
                          "settled exp %0b got %0b"},
                         checked, want.x_position, got.x_position, want.y_position,
                         got.y_position, want.settled, got.settled);
        end
    endfunction
endclass

module tb_damped_spring_2d_step_core;

    localparam int FRACTION_BITS   = 16;
    localparam int CLK_PERIOD      = 10;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int PHASE_REQUESTS  = 76;
    localparam int NUM_PHASES      = 8;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_ready;
    dspring_pkg::t_in_item               i_in_data;
    logic                                o_out_valid;
    logic                                i_out_ready;
    dspring_pkg::t_out_item              o_out_data;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [dspring_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [31:0]                         i_cfg_data;

    spring_scoreboard #(FRACTION_BITS) sb;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    int idle_cycles;
    int requests_sent;

    damped_spring_2d_step_core #(
        .FRACTION_BITS(FRACTION_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receive result transactions, then pick the next ready level
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Count cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog
    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("[damped_spring_2d_step_core] ERROR");
        $finish;
    end

    // Offer one request, idling first at the current sender rate, and hold until accepted
    task automatic send_request(dspring_pkg::t_req kind, logic [31:0] x_val,
                                logic [31:0] y_val);
        dspring_pkg::t_in_item item;
        int gap;
        item.req_type  = kind;
        item.x_operand = x_val;
        item.y_operand = y_val;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(item);
        requests_sent++;
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_positions.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all four registers back to back
    task automatic apply_settings(logic [31:0] k, logic [31:0] d, logic [31:0] pl,
                                  logic [31:0] vl);
        logic [31:0]           vals [4];
        dspring_pkg::t_cfg_idx regs [4];
        vals = '{k, d, pl, vl};
        regs = '{dspring_pkg::CFG_STIFFNESS, dspring_pkg::CFG_DAMPING,
                 dspring_pkg::CFG_POS_LIMIT, dspring_pkg::CFG_VEL_LIMIT};
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_register(regs[r], vals[r]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Offset within about four units of zero
    function automatic logic [31:0] near_value();
        return 32'(int'($urandom_range(0, 524288)) - 262144);
    endfunction

    // Any 32-bit value, biased toward the wrap points
    function automatic logic [31:0] wild_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Mostly snap / aim / kick / settle sequences, the rest arbitrary requests
    task automatic run_random(int count, bit with_hold);
        int start;
        int ticks;
        bit hold_done;
        logic [31:0] anchor_x;
        logic [31:0] anchor_y;
        start     = requests_sent;
        hold_done = 1'b0;
        while (requests_sent - start < count) begin
            if (with_hold && !hold_done && requests_sent - start >= count / 3) begin
                hold_request = HOLD_OFF_CYCLES;
                hold_done    = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                anchor_x = near_value();
                anchor_y = near_value();
                send_request(dspring_pkg::REQ_SNAP, anchor_x, anchor_y);
                if ($urandom_range(0, 1))
                    send_request(dspring_pkg::REQ_TARGET, anchor_x + near_value(),
                                 anchor_y + near_value());
                if ($urandom_range(0, 2) == 0)
                    send_request(dspring_pkg::REQ_IMPULSE, near_value(), near_value());
                ticks = $urandom_range(3, 24);
                repeat (ticks) send_request(dspring_pkg::REQ_TICK, $urandom(), $urandom());
            end else begin
                send_request(dspring_pkg::t_req'($urandom_range(0, 3)),
                             wild_value(), wild_value());
            end
        end
    endtask

    // Main sequence
    initial begin
        logic [31:0] settings [NUM_PHASES][4];
        sb             = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        hold_left      = 0;
        idle_cycles    = 0;
        requests_sent  = 0;

        settings[0] = '{32'd131071, 32'd131071, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        settings[1] = '{32'd0, 32'd0, 32'd0, 32'd0};
        settings[2] = '{32'd13107, 32'd32768, 32'd32768, 32'd6553};
        settings[3] = '{$urandom_range(0, 131071), $urandom_range(0, 131071),
                        $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 24),
                        $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 24)};
        settings[4] = '{32'd65536, 32'd0, 32'd65536, 32'd16384};
        settings[5] = '{$urandom_range(0, 131071), $urandom_range(0, 131071),
                        $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h7FFF_FFFF)};
        settings[6] = '{32'd13107, 32'd32768,
                        $urandom_range(0, 262144), $urandom_range(0, 65536)};
        settings[7] = '{$urandom_range(0, 131071), $urandom_range(0, 131071),
                        $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 30),
                        $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 30)};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on reset register values
        // at rest, operands ignored
        send_request(dspring_pkg::REQ_TICK, 32'hDEAD_BEEF, 32'h1234_5678);
        send_request(dspring_pkg::REQ_SNAP, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(dspring_pkg::REQ_TICK, 32'hFFFF_FFFF, 32'h0000_0000);
        // offsets wrap
        send_request(dspring_pkg::REQ_TARGET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(dspring_pkg::REQ_TICK, 32'h0, 32'h0);
        send_request(dspring_pkg::REQ_TICK, 32'h0, 32'h0);
        send_request(dspring_pkg::REQ_IMPULSE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(dspring_pkg::REQ_TICK, 32'h0, 32'h0);
        send_request(dspring_pkg::REQ_SNAP, 32'h0, 32'h0);
        // most negative velocity, then wrap back to zero
        send_request(dspring_pkg::REQ_IMPULSE, 32'h8000_0000, 32'h0);
        send_request(dspring_pkg::REQ_IMPULSE, 32'h8000_0000, 32'h0);
        // offset equal to limit, then just under it
        send_request(dspring_pkg::REQ_TARGET, 32'h0000_8000, 32'h0);
        send_request(dspring_pkg::REQ_TARGET, 32'h0000_7FFF, 32'h0);
        // most negative offset
        send_request(dspring_pkg::REQ_SNAP, 32'h8000_0000, 32'h0);
        send_request(dspring_pkg::REQ_TARGET, 32'h0, 32'h0);
        send_request(dspring_pkg::REQ_TICK, 32'h0, 32'h0);
        // velocity equal to limit, then just under it
        send_request(dspring_pkg::REQ_SNAP, 32'hFFFF_FFFF, 32'h0000_0001);
        send_request(dspring_pkg::REQ_IMPULSE, 32'h0000_1999, 32'h0);
        send_request(dspring_pkg::REQ_IMPULSE, 32'hFFFF_FFFF, 32'h0);
        send_request(dspring_pkg::REQ_TARGET, 32'h0004_0000, 32'hFFFC_0000);
        repeat (4) send_request(dspring_pkg::REQ_TICK, 32'h0, 32'h0);
        drain_results();

        // Random phases, each with its own register values and one of four flow-control mixes
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            apply_settings(settings[phase][0], settings[phase][1],
                           settings[phase][2], settings[phase][3]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            run_random(PHASE_REQUESTS, phase == 2 || phase == 5);
            drain_results();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge i_clk);

        if (sb.pending_positions.size() != 0) begin
            $display("%0d predicted results never arrived", sb.pending_positions.size());
            sb.failures++;
        end
        $display("Spring core: %0d requests sent, %0d results compared", requests_sent,
                 sb.checked);
        $display("Covered %0d register settings under four sender/receiver idle mixes",
                 NUM_PHASES + 1);
        if (sb.failures == 0)
            $display("[damped_spring_2d_step_core] OK");
        else
            $display("[damped_spring_2d_step_core] ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/dspring_pkg.sv
hw/rtl/dspring_axis.sv
hw/rtl/damped_spring_2d_step_core.sv
hw/rtl/dspring_checker.sv
tb/sv/tb_damped_spring_2d_step_core.sv
